@@ rtl/rkce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_pkg
// Shared widths, codes, node entry type and midpoint helper for the range
// k-th / count engine.
// ----------------------------------------------------------------------------
package rkce_pkg;

   localparam int MAX_ITEMS   = 1024;
   localparam int VALUE_BITS  = 16;
   localparam int TREE_LEVELS = 16;

   localparam int VAL_W     = VALUE_BITS;
   localparam int POS_W     = 11;
   localparam int OP_W      = 3;
   localparam int ANS_W     = 16;
   localparam int ST_W      = 3;
   localparam int CSR_IDX_W = 2;

   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int LVL_W     = $clog2(TREE_LEVELS + 1);
   localparam int PFX_ROW   = MAX_ITEMS + 1;
   localparam int PFX_DEPTH = TREE_LEVELS * PFX_ROW;
   localparam int PFX_AW    = $clog2(PFX_DEPTH);

   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_BUILD  = 3'd1;
   localparam logic [OP_W-1:0] OP_KTH    = 3'd2;
   localparam logic [OP_W-1:0] OP_CNT_EQ = 3'd3;
   localparam logic [OP_W-1:0] OP_CNT_GT = 3'd4;
   localparam logic [OP_W-1:0] OP_CNT_GE = 3'd5;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD_RANGE = 3'd1;
   localparam logic [ST_W-1:0] ST_BAD_K     = 3'd2;
   localparam logic [ST_W-1:0] ST_BAD_VALUE = 3'd3;
   localparam logic [ST_W-1:0] ST_NOT_BUILT = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_MAX = 2'd1;

   typedef logic signed [VAL_W-1:0] value_type;

   // one element of a level: its value and the interval of its node
   typedef struct packed {
      value_type value;
      value_type lo;
      value_type hi;
   } entry_type;

   // floor((a+b)/2) via arithmetic shift of the widened sum
   function automatic value_type floor_mid(input value_type a, input value_type b);
      logic signed [VAL_W:0] sum;
      logic signed [VAL_W:0] half;
      sum  = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      half = sum >>> 1;
      return half[VAL_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/rkce_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_req_if
// Request channel: opcode and operands of one item.
// ----------------------------------------------------------------------------
interface rkce_req_if;
   import rkce_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic signed [VAL_W-1:0] value;
   logic [POS_W-1:0]        left_pos;
   logic [POS_W-1:0]        right_pos;
   logic [POS_W-1:0]        k_rank;

   modport source (output valid, output opcode, output value, output left_pos,
                   output right_pos, output k_rank, input ready);
   modport sink   (input valid, input opcode, input value, input left_pos,
                   input right_pos, input k_rank, output ready);
endinterface
`default_nettype wire

@@ rtl/rkce_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_rsp_if
// Response channel: answer and status of one item.
// ----------------------------------------------------------------------------
interface rkce_rsp_if;
   import rkce_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ANS_W-1:0] answer;
   logic [ST_W-1:0]         status;

   modport source (output valid, output answer, output status, input ready);
   modport sink   (input valid, input answer, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/rkce_csr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rkce_csr_if;
   import rkce_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VAL_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/range_kth_and_count_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// range_kth_and_count_engine
// Wavelet tree over loaded signed values: range k-th smallest and range
// counts (equal, greater, not less), built level by level in memories.
//
//   channel   dir   payload                                    beat when
//   req_if    in    opcode, value, left_pos, right_pos, k_rank  valid & ready
//   rsp_if    out   answer, status                              valid & ready
//   csr_if    in    index, data (value_min, value_max)          valid & ready
//
// load, unknown opcode or rejected item: S_FINISH sets the response register.
// build: a copy pass into partition buffer 0, then per level one forward and
//   one reverse stream through the partition buffers, 16 levels.
// query: up to 16 levels, each a check, the four prefix-count reads on the
//   single read port of the prefix memory, and an update.
// req_if.ready is high only while idle; a pending response does not block
//   a new request. csr_if is always ready. Synchronous reset, no clear pass.
// ----------------------------------------------------------------------------
module range_kth_and_count_engine (
   input  logic       clock,
   input  logic       reset,
   rkce_req_if.sink   req_if,
   rkce_rsp_if.source rsp_if,
   rkce_csr_if.sink   csr_if
);
   import rkce_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FINISH = 4'd1;
   localparam logic [3:0] S_COPY   = 4'd2;
   localparam logic [3:0] S_LINIT  = 4'd3;
   localparam logic [3:0] S_FWD    = 4'd4;
   localparam logic [3:0] S_REV    = 4'd5;
   localparam logic [3:0] S_QCHK   = 4'd6;
   localparam logic [3:0] S_QRD    = 4'd7;
   localparam logic [3:0] S_QCALC  = 4'd8;

   // control
   logic [3:0]       state_ff, state_in;
   value_type        vmin_ff, vmin_in, vmax_ff, vmax_in;
   logic [CNT_W-1:0] item_cnt_ff, item_cnt_in;
   logic             built_ff, built_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic             p_vld_ff, p_vld_in;
   logic [2:0]       phase_ff, phase_in;

   // payload
   logic signed [ANS_W-1:0] res_ans_ff, res_ans_in, rsp_ans_ff, rsp_ans_in;
   logic [ST_W-1:0]         res_st_ff, res_st_in, rsp_st_ff, rsp_st_in;
   logic [PFX_AW-1:0]       base_ff, base_in;
   logic [IDX_W-1:0]        p_idx_ff, p_idx_in, w_ff, w_in;
   logic                    first_ff, first_in;
   value_type               prev_lo_ff, prev_lo_in;
   logic [CNT_W-1:0]        low_cnt_ff, low_cnt_in;
   logic [OP_W-1:0]         q_mode_ff, q_mode_in;
   value_type               q_v_ff, q_v_in, q_lo_ff, q_lo_in, q_hi_ff, q_hi_in;
   logic [CNT_W-1:0]        q_s_ff, q_s_in, q_size_ff, q_size_in;
   logic [CNT_W-1:0]        q_gl_ff, q_gl_in, q_gr_ff, q_gr_in;
   logic [CNT_W-1:0]        q_k_ff, q_k_in, q_acc_ff, q_acc_in;
   logic [CNT_W-1:0]        c_s_ff, c_s_in, c_gl_ff, c_gl_in;
   logic [CNT_W-1:0]        c_gr_ff, c_gr_in, c_end_ff, c_end_in;

   // memories
   logic              st_we;
   logic [IDX_W-1:0]  st_waddr, st_raddr;
   value_type         st_wdata, st_rdata;
   logic              b0_we, b1_we;
   logic [IDX_W-1:0]  b_waddr, b_raddr;
   entry_type         b_wdata, b0_rdata, b1_rdata;
   logic              pf_we;
   logic [PFX_AW-1:0] pf_waddr, pf_raddr;
   logic [CNT_W-1:0]  pf_wdata, pf_rdata;

   rkce_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata));

   rkce_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_ITEMS)) u_buf0 (
      .clock(clock), .wr_en(b0_we), .wr_addr(b_waddr), .wr_data(b_wdata),
      .rd_addr(b_raddr), .rd_data(b0_rdata));

   rkce_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_ITEMS)) u_buf1 (
      .clock(clock), .wr_en(b1_we), .wr_addr(b_waddr), .wr_data(b_wdata),
      .rd_addr(b_raddr), .rd_data(b1_rdata));

   rkce_ram #(.WIDTH(CNT_W), .DEPTH(PFX_DEPTH)) u_prefix (
      .clock(clock), .wr_en(pf_we), .wr_addr(pf_waddr), .wr_data(pf_wdata),
      .rd_addr(pf_raddr), .rd_data(pf_rdata));

   // streaming datapath for build passes
   entry_type        src_e;
   value_type        mid_b;
   logic             go_low, seg_new, issuing;
   logic [IDX_W-1:0] w_cur, iss_idx;
   logic [CNT_W-1:0] rev_idx;

   assign src_e   = lvl_ff[0] ? b1_rdata : b0_rdata;
   assign mid_b   = floor_mid(src_e.lo, src_e.hi);
   assign go_low  = (src_e.lo == src_e.hi) || (src_e.value <= mid_b);
   assign seg_new = first_ff || (src_e.lo != prev_lo_ff);
   assign w_cur   = seg_new ? p_idx_ff : w_ff;
   assign issuing = rd_cnt_ff < item_cnt_ff;
   assign rev_idx = item_cnt_ff - rd_cnt_ff - CNT_W'(1);
   assign iss_idx = (state_ff == S_REV) ? rev_idx[IDX_W-1:0] : rd_cnt_ff[IDX_W-1:0];

   // query datapath
   value_type        q_mid;
   logic [CNT_W-1:0] ml, mr, lt, left_n, q_all;
   logic             kth_done, chk_done;
   logic [CNT_W-1:0] chk_val;

   assign q_mid    = floor_mid(q_lo_ff, q_hi_ff);
   assign ml       = c_gl_ff - c_s_ff;
   assign mr       = c_gr_ff - c_s_ff;
   assign lt       = c_end_ff - c_s_ff;
   assign left_n   = mr - ml;
   assign q_all    = q_gr_ff - q_gl_ff;
   assign kth_done = (lvl_ff == LVL_W'(TREE_LEVELS)) || (q_lo_ff == q_hi_ff);

   always_comb begin
      chk_done = 1'b0;
      chk_val  = q_acc_ff;
      if (q_all == '0) begin
         chk_done = 1'b1;
      end else if (q_mode_ff == OP_CNT_EQ) begin
         if (q_v_ff < q_lo_ff || q_v_ff > q_hi_ff) begin
            chk_done = 1'b1;
         end else if (q_lo_ff == q_hi_ff) begin
            chk_done = 1'b1;
            chk_val  = q_acc_ff + q_all;
         end
      end else if (q_mode_ff == OP_CNT_GT) begin
         if (q_hi_ff <= q_v_ff) begin
            chk_done = 1'b1;
         end else if (q_lo_ff > q_v_ff) begin
            chk_done = 1'b1;
            chk_val  = q_acc_ff + q_all;
         end
      end else begin
         if (q_hi_ff < q_v_ff) begin
            chk_done = 1'b1;
         end else if (q_lo_ff >= q_v_ff) begin
            chk_done = 1'b1;
            chk_val  = q_acc_ff + q_all;
         end
      end
      if (!chk_done && lvl_ff == LVL_W'(TREE_LEVELS)) begin
         chk_done = 1'b1;
      end
   end

   // front-end checks on the request
   logic             load_bad, build_bad, range_bad, k_bad;
   logic [VAL_W:0]   span;
   logic [CNT_W-1:0] range_len;

   assign span      = {vmax_ff[VAL_W-1], vmax_ff} - {vmin_ff[VAL_W-1], vmin_ff};
   assign build_bad = (vmin_ff > vmax_ff) || ((span >> TREE_LEVELS) != '0);
   assign load_bad  = (req_if.value < vmin_ff) || (req_if.value > vmax_ff) ||
                      (item_cnt_ff >= CNT_W'(MAX_ITEMS));
   assign range_bad = (req_if.left_pos == '0) || (req_if.right_pos > item_cnt_ff) ||
                      (req_if.left_pos > req_if.right_pos);
   assign range_len = req_if.right_pos - req_if.left_pos + CNT_W'(1);
   assign k_bad     = (req_if.k_rank == '0) || (req_if.k_rank > range_len);

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_vld_ff;
   assign rsp_if.answer = rsp_ans_ff;
   assign rsp_if.status = rsp_st_ff;
   assign csr_if.ready  = 1'b1;

   always_comb begin
      state_in    = state_ff;
      vmin_in     = vmin_ff;
      vmax_in     = vmax_ff;
      item_cnt_in = item_cnt_ff;
      built_in    = built_ff;
      rsp_vld_in  = rsp_vld_ff;
      lvl_in      = lvl_ff;
      rd_cnt_in   = rd_cnt_ff;
      p_vld_in    = 1'b0;
      phase_in    = phase_ff;
      res_ans_in  = res_ans_ff;
      res_st_in   = res_st_ff;
      rsp_ans_in  = rsp_ans_ff;
      rsp_st_in   = rsp_st_ff;
      base_in     = base_ff;
      p_idx_in    = iss_idx;
      w_in        = w_ff;
      first_in    = first_ff;
      prev_lo_in  = prev_lo_ff;
      low_cnt_in  = low_cnt_ff;
      q_mode_in   = q_mode_ff;
      q_v_in      = q_v_ff;
      q_lo_in     = q_lo_ff;
      q_hi_in     = q_hi_ff;
      q_s_in      = q_s_ff;
      q_size_in   = q_size_ff;
      q_gl_in     = q_gl_ff;
      q_gr_in     = q_gr_ff;
      q_k_in      = q_k_ff;
      q_acc_in    = q_acc_ff;
      c_s_in      = c_s_ff;
      c_gl_in     = c_gl_ff;
      c_gr_in     = c_gr_ff;
      c_end_in    = c_end_ff;

      st_we    = 1'b0;
      st_waddr = item_cnt_ff[IDX_W-1:0];
      st_wdata = req_if.value;
      st_raddr = iss_idx;
      b0_we    = 1'b0;
      b1_we    = 1'b0;
      b_raddr  = iss_idx;
      b_waddr  = w_cur;
      b_wdata  = src_e;
      pf_we    = 1'b0;
      pf_waddr = base_ff;
      pf_wdata = '0;
      pf_raddr = base_ff;

      if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               res_ans_in = '0;
               res_st_in  = ST_OK;
               state_in   = S_FINISH;
               lvl_in     = '0;
               base_in    = '0;
               rd_cnt_in  = '0;
               if (req_if.opcode == OP_LOAD) begin
                  if (load_bad) begin
                     res_st_in = ST_BAD_VALUE;
                  end else begin
                     st_we       = 1'b1;
                     item_cnt_in = item_cnt_ff + CNT_W'(1);
                     built_in    = 1'b0;
                  end
               end else if (req_if.opcode == OP_BUILD) begin
                  built_in = 1'b0;
                  if (build_bad) begin
                     res_st_in = ST_BAD_VALUE;
                  end else if (item_cnt_ff == '0) begin
                     built_in = 1'b1;
                  end else begin
                     state_in = S_COPY;
                  end
               end else if (req_if.opcode == OP_KTH || req_if.opcode == OP_CNT_EQ ||
                            req_if.opcode == OP_CNT_GT || req_if.opcode == OP_CNT_GE) begin
                  if (!built_ff) begin
                     res_st_in = ST_NOT_BUILT;
                  end else if (range_bad) begin
                     res_st_in = ST_BAD_RANGE;
                  end else if (req_if.opcode == OP_KTH && k_bad) begin
                     res_st_in = ST_BAD_K;
                  end else begin
                     state_in  = S_QCHK;
                     q_mode_in = req_if.opcode;
                     q_v_in    = req_if.value;
                     q_lo_in   = vmin_ff;
                     q_hi_in   = vmax_ff;
                     q_s_in    = '0;
                     q_size_in = item_cnt_ff;
                     q_gl_in   = req_if.left_pos - CNT_W'(1);
                     q_gr_in   = req_if.right_pos;
                     q_k_in    = req_if.k_rank;
                     q_acc_in  = '0;
                  end
               end
            end
         end

         S_FINISH: begin
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_vld_in = 1'b1;
               rsp_ans_in = res_ans_ff;
               rsp_st_in  = res_st_ff;
               state_in   = S_IDLE;
            end
         end

         S_COPY: begin
            p_vld_in  = issuing;
            rd_cnt_in = rd_cnt_ff + CNT_W'(issuing);
            b_waddr   = p_idx_ff;
            b_wdata   = '{value: st_rdata, lo: vmin_ff, hi: vmax_ff};
            b0_we     = p_vld_ff;
            if (!issuing && !p_vld_ff) begin
               state_in = S_LINIT;
            end
         end

         S_LINIT: begin
            // first prefix entry of the level is zero
            pf_we      = 1'b1;
            pf_waddr   = base_ff;
            pf_wdata   = '0;
            rd_cnt_in  = '0;
            first_in   = 1'b1;
            low_cnt_in = '0;
            state_in   = S_FWD;
         end

         S_FWD: begin
            // lows of each node go first, in order
            p_vld_in  = issuing;
            rd_cnt_in = rd_cnt_ff + CNT_W'(issuing);
            if (p_vld_ff) begin
               pf_we      = 1'b1;
               pf_waddr   = base_ff + PFX_AW'(p_idx_ff) + PFX_AW'(1);
               pf_wdata   = low_cnt_ff + CNT_W'(go_low);
               low_cnt_in = low_cnt_ff + CNT_W'(go_low);
               b_wdata    = '{value: src_e.value, lo: src_e.lo,
                              hi: (src_e.lo == src_e.hi) ? src_e.hi : mid_b};
               b0_we      = go_low && lvl_ff[0];
               b1_we      = go_low && !lvl_ff[0];
               w_in       = w_cur + IDX_W'(go_low);
               prev_lo_in = src_e.lo;
               first_in   = 1'b0;
            end
            if (!issuing && !p_vld_ff) begin
               rd_cnt_in = '0;
               first_in  = 1'b1;
               state_in  = S_REV;
            end
         end

         S_REV: begin
            // highs fill each node from its end backward, keeping order
            p_vld_in  = issuing;
            rd_cnt_in = rd_cnt_ff + CNT_W'(issuing);
            if (p_vld_ff) begin
               b_wdata    = '{value: src_e.value, lo: mid_b + value_type'(1), hi: src_e.hi};
               b0_we      = !go_low && lvl_ff[0];
               b1_we      = !go_low && !lvl_ff[0];
               w_in       = w_cur - IDX_W'(!go_low);
               prev_lo_in = src_e.lo;
               first_in   = 1'b0;
            end
            if (!issuing && !p_vld_ff) begin
               lvl_in  = lvl_ff + LVL_W'(1);
               base_in = base_ff + PFX_AW'(PFX_ROW);
               if (lvl_ff == LVL_W'(TREE_LEVELS - 1)) begin
                  built_in = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_LINIT;
               end
            end
         end

         S_QCHK: begin
            phase_in = '0;
            if (q_mode_ff == OP_KTH) begin
               if (kth_done) begin
                  res_ans_in = ANS_W'(q_lo_ff);
                  state_in   = S_FINISH;
               end else begin
                  state_in = S_QRD;
               end
            end else begin
               if (chk_done) begin
                  res_ans_in = ANS_W'(chk_val);
                  state_in   = S_FINISH;
               end else begin
                  state_in = S_QRD;
               end
            end
         end

         S_QRD: begin
            priority case (phase_ff)
               3'd0:    pf_raddr = base_ff + PFX_AW'(q_s_ff);
               3'd1:    pf_raddr = base_ff + PFX_AW'(q_gl_ff);
               3'd2:    pf_raddr = base_ff + PFX_AW'(q_gr_ff);
               default: pf_raddr = base_ff + PFX_AW'(q_s_ff + q_size_ff);
            endcase
            priority case (phase_ff)
               3'd1:    c_s_in   = pf_rdata;
               3'd2:    c_gl_in  = pf_rdata;
               3'd3:    c_gr_in  = pf_rdata;
               3'd4:    c_end_in = pf_rdata;
               default: ;
            endcase
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd4) begin
               state_in = S_QCALC;
            end
         end

         S_QCALC: begin
            lvl_in   = lvl_ff + LVL_W'(1);
            base_in  = base_ff + PFX_AW'(PFX_ROW);
            state_in = S_QCHK;
            if ((q_mode_ff == OP_KTH) ? (q_k_ff <= left_n) : (q_v_ff <= q_mid)) begin
               if (q_mode_ff != OP_KTH && q_mode_ff != OP_CNT_EQ) begin
                  q_acc_in = q_acc_ff + q_all - left_n;
               end
               q_hi_in   = q_mid;
               q_gl_in   = q_s_ff + ml;
               q_gr_in   = q_s_ff + mr;
               q_size_in = lt;
            end else begin
               if (q_mode_ff == OP_KTH) begin
                  q_k_in = q_k_ff - left_n;
               end
               q_lo_in   = q_mid + value_type'(1);
               q_gl_in   = q_gl_ff + lt - ml;
               q_gr_in   = q_gr_ff + lt - mr;
               q_s_in    = q_s_ff + lt;
               q_size_in = q_size_ff - lt;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_if.valid) begin
         if (csr_if.index == CSR_VALUE_MIN) begin
            vmin_in  = csr_if.data;
            built_in = 1'b0;
         end else if (csr_if.index == CSR_VALUE_MAX) begin
            vmax_in  = csr_if.data;
            built_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         vmin_ff     <= '0;
         vmax_ff     <= value_type'(255);
         item_cnt_ff <= '0;
         built_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         lvl_ff      <= '0;
         rd_cnt_ff   <= '0;
         p_vld_ff    <= 1'b0;
         phase_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         vmin_ff     <= vmin_in;
         vmax_ff     <= vmax_in;
         item_cnt_ff <= item_cnt_in;
         built_ff    <= built_in;
         rsp_vld_ff  <= rsp_vld_in;
         lvl_ff      <= lvl_in;
         rd_cnt_ff   <= rd_cnt_in;
         p_vld_ff    <= p_vld_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ans_ff <= res_ans_in;
      res_st_ff  <= res_st_in;
      rsp_ans_ff <= rsp_ans_in;
      rsp_st_ff  <= rsp_st_in;
      base_ff    <= base_in;
      p_idx_ff   <= p_idx_in;
      w_ff       <= w_in;
      first_ff   <= first_in;
      prev_lo_ff <= prev_lo_in;
      low_cnt_ff <= low_cnt_in;
      q_mode_ff  <= q_mode_in;
      q_v_ff     <= q_v_in;
      q_lo_ff    <= q_lo_in;
      q_hi_ff    <= q_hi_in;
      q_s_ff     <= q_s_in;
      q_size_ff  <= q_size_in;
      q_gl_ff    <= q_gl_in;
      q_gr_ff    <= q_gr_in;
      q_k_ff     <= q_k_in;
      q_acc_ff   <= q_acc_in;
      c_s_ff     <= c_s_in;
      c_gl_ff    <= c_gl_in;
      c_gr_ff    <= c_gr_in;
      c_end_ff   <= c_end_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      item_cnt_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count above capacity");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff) == S_FINISH)
      else $error("response raised outside finish");

   a_built_after_build: assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> ($past(state_ff) == S_REV || $past(state_ff) == S_IDLE))
      else $error("tree marked built without a build");

   a_low_write_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FWD && p_vld_ff && go_low) |-> w_cur <= p_idx_ff)
      else $error("partition write ahead of read");

   a_query_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QRD || state_ff == S_QCALC) |-> lvl_ff < LVL_W'(TREE_LEVELS))
      else $error("query descended past the last level");

endmodule
`default_nettype wire

@@ rtl/rkce_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rkce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ verif/range_kth_and_count_checker.sv @@
// ----------------------------------------------------------------------------
// range_kth_and_count_checker
// Watches the request, response and register channels of the engine, keeps
// its own wavelet tree over the accepted loads, predicts answer and status
// of every request and compares each response beat against the oldest one.
// ----------------------------------------------------------------------------
module range_kth_and_count_checker (
   input  logic clock,
   input  logic reset,
   rkce_req_if  req,
   rkce_rsp_if  rsp,
   rkce_csr_if  csr,
   output int   fail_count,
   output int   pending
);
   import rkce_pkg::*;

   typedef struct packed {
      logic [ANS_W-1:0] answer;
      logic [ST_W-1:0]  status;
   } outcome_type;

   outcome_type expected_q[$];
   longint      range_lo;
   longint      range_hi;
   longint      stored[MAX_ITEMS];
   longint      scratch[MAX_ITEMS];
   longint      shuffled[MAX_ITEMS];
   int unsigned low_prefix[TREE_LEVELS][MAX_ITEMS+1];
   int unsigned stored_count;
   bit          tree_ready;

   initial fail_count = 0;
   assign pending = expected_q.size();

   function automatic longint half_point(longint a, longint b);
      return (a + b) >>> 1;
   endfunction

   // interval of the node that holds v at the given depth
   function automatic void node_span(input longint v, input int depth,
                                     output longint lo, output longint hi);
      longint a;
      longint b;
      longint m;
      a = range_lo;
      b = range_hi;
      for (int i = 0; i < depth && a != b; i++) begin
         m = half_point(a, b);
         if (v <= m) b = m; else a = m + 1;
      end
      lo = a;
      hi = b;
   endfunction

   function automatic bit build_levels();
      longint lo, hi, lo2, hi2, m;
      int unsigned i, e, w;
      if (range_lo > range_hi) return 0;
      if (((range_hi - range_lo) >> TREE_LEVELS) != 0) return 0;
      for (int j = 0; j < stored_count; j++) scratch[j] = stored[j];
      for (int d = 0; d < TREE_LEVELS; d++) begin
         low_prefix[d][0] = 0;
         for (i = 0; i < stored_count; i++) begin
            node_span(scratch[i], d, lo, hi);
            low_prefix[d][i+1] = low_prefix[d][i] +
               (((lo == hi) || (scratch[i] <= half_point(lo, hi))) ? 1 : 0);
         end
         // stable split of each node: low half first, then high half
         i = 0;
         while (i < stored_count) begin
            w = i;
            e = i;
            node_span(scratch[i], d, lo, hi);
            while (e < stored_count) begin
               node_span(scratch[e], d, lo2, hi2);
               if (lo2 != lo) break;
               e++;
            end
            m = half_point(lo, hi);
            for (int j = i; j < e; j++)
               if (lo == hi || scratch[j] <= m) shuffled[w++] = scratch[j];
            for (int j = i; j < e; j++)
               if (!(lo == hi || scratch[j] <= m)) shuffled[w++] = scratch[j];
            i = e;
         end
         for (int j = 0; j < stored_count; j++) scratch[j] = shuffled[j];
      end
      return 1;
   endfunction

   function automatic longint kth_value(int unsigned gl, int unsigned gr, int unsigned k);
      longint lo, hi, m;
      int unsigned s, size, base, ml, mr, lt, left;
      lo = range_lo;
      hi = range_hi;
      s = 0;
      size = stored_count;
      for (int d = 0; d < TREE_LEVELS && lo != hi; d++) begin
         base = low_prefix[d][s];
         ml   = low_prefix[d][gl] - base;
         mr   = low_prefix[d][gr] - base;
         lt   = low_prefix[d][s+size] - base;
         left = mr - ml;
         m    = half_point(lo, hi);
         if (k <= left) begin
            hi = m;
            gl = s + ml;
            gr = s + mr;
            size = lt;
         end else begin
            k  -= left;
            lo = m + 1;
            gl = s + lt + (gl - s - ml);
            gr = s + lt + (gr - s - mr);
            s  += lt;
            size -= lt;
         end
      end
      return lo;
   endfunction

   function automatic int unsigned count_where(logic [OP_W-1:0] op, longint v,
                                               int unsigned gl, int unsigned gr);
      longint lo, hi, m;
      int unsigned s, size, acc, all, base, ml, mr, lt;
      lo = range_lo;
      hi = range_hi;
      s = 0;
      size = stored_count;
      acc = 0;
      for (int d = 0; d <= TREE_LEVELS; d++) begin
         all = gr - gl;
         if (all == 0) return acc;
         case (op)
            OP_CNT_EQ: begin
               if (v < lo || v > hi) return acc;
               if (lo == hi) return acc + all;
            end
            OP_CNT_GT: begin
               if (hi <= v) return acc;
               if (lo > v) return acc + all;
            end
            default: begin
               if (hi < v) return acc;
               if (lo >= v) return acc + all;
            end
         endcase
         if (d == TREE_LEVELS) return acc;
         base = low_prefix[d][s];
         ml   = low_prefix[d][gl] - base;
         mr   = low_prefix[d][gr] - base;
         lt   = low_prefix[d][s+size] - base;
         m    = half_point(lo, hi);
         if (v <= m) begin
            if (op != OP_CNT_EQ) acc += all - (mr - ml);
            hi = m;
            gl = s + ml;
            gr = s + mr;
            size = lt;
         end else begin
            lo = m + 1;
            gl = s + lt + (gl - s - ml);
            gr = s + lt + (gr - s - mr);
            s  += lt;
            size -= lt;
         end
      end
      return acc;
   endfunction

   function automatic outcome_type predict_outcome(logic [OP_W-1:0] op, longint v,
                                                   int unsigned l, int unsigned r,
                                                   int unsigned k);
      outcome_type res;
      int unsigned c;
      res = '0;
      case (op)
         OP_LOAD: begin
            if (v < range_lo || v > range_hi || stored_count >= MAX_ITEMS) begin
               res.status = ST_BAD_VALUE;
            end else begin
               stored[stored_count++] = v;
               tree_ready = 0;
            end
         end
         OP_BUILD: begin
            tree_ready = build_levels();
            if (!tree_ready) res.status = ST_BAD_VALUE;
         end
         OP_KTH, OP_CNT_EQ, OP_CNT_GT, OP_CNT_GE: begin
            if (!tree_ready) res.status = ST_NOT_BUILT;
            else if (l < 1 || r > stored_count || l > r) res.status = ST_BAD_RANGE;
            else if (op == OP_KTH) begin
               if (k < 1 || k > r - l + 1) res.status = ST_BAD_K;
               else res.answer = ANS_W'(kth_value(l - 1, r, k));
            end else begin
               c = count_where(op, v, l - 1, r);
               res.answer = (c > 32767) ? ANS_W'(32767) : ANS_W'(c);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         range_lo     = 0;
         range_hi     = 255;
         stored_count = 0;
         tree_ready   = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response beat with nothing outstanding", rsp.answer, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp.answer !== want.answer)
                  report_mismatch("answer", rsp.answer, want.answer);
               if (rsp.status !== want.status)
                  report_mismatch("status", 16'(rsp.status), 16'(want.status));
            end
         end
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_VALUE_MIN) begin
               range_lo   = $signed(csr.data);
               tree_ready = 0;
            end else if (csr.index == CSR_VALUE_MAX) begin
               range_hi   = $signed(csr.data);
               tree_ready = 0;
            end
         end
         if (req.valid && req.ready)
            expected_q.insert(expected_q.size(),
                              predict_outcome(req.opcode, req.value, req.left_pos,
                                              req.right_pos, req.k_rank));
      end
   end

endmodule

@@ verif/range_kth_and_count_engine_tb.sv @@
// ----------------------------------------------------------------------------
// range_kth_and_count_engine_tb
// Drives the engine through directed corner items and then rounds of loads,
// a build and range queries under several value intervals and several
// mixes of sender gaps and receiver stalls; ends by filling the store.
// ----------------------------------------------------------------------------
module range_kth_and_count_engine_tb;
   import rkce_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   logic   clock = 0;
   logic   reset = 1;
   int     fail_count;
   int     pending;
   int     idle_pct  = 0;
   int     stall_pct = 0;
   int     loaded    = 0;
   int     sent      = 0;
   longint span_lo   = 0;
   longint span_hi   = 255;

   rkce_req_if req_bus ();
   rkce_rsp_if rsp_bus ();
   rkce_csr_if csr_bus ();

   range_kth_and_count_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   range_kth_and_count_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr        (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   task automatic send(logic [OP_W-1:0] op, logic [15:0] v, int l, int r, int k);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid     <= 1;
      req_bus.opcode    <= op;
      req_bus.value     <= v;
      req_bus.left_pos  <= POS_W'(l);
      req_bus.right_pos <= POS_W'(r);
      req_bus.k_rank    <= POS_W'(k);
      do @(posedge clock); while (!req_bus.ready);
      // the store only grows on a load that fits the interval
      if (op == OP_LOAD && $signed(v) >= span_lo && $signed(v) <= span_hi &&
          loaded < MAX_ITEMS)
         loaded++;
      sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint data);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= data[15:0];
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 0;
   endtask

   task automatic set_span(longint lo, longint hi);
      drain();
      write_reg(CSR_VALUE_MIN, lo);
      write_reg(CSR_VALUE_MAX, hi);
      span_lo = lo;
      span_hi = hi;
   endtask

   function automatic logic [15:0] pick_value(int slack);
      longint lo, hi;
      lo = span_lo - slack;
      hi = span_hi + slack;
      if (lo < -32768) lo = -32768;
      if (hi > 32767) hi = 32767;
      return 16'(lo + $urandom_range(0, 32'(hi - lo)));
   endfunction

   task automatic send_query();
      int l, r;
      logic [OP_W-1:0] op;
      op = OP_KTH + OP_W'($urandom_range(0, 3));
      l  = $urandom_range(1, loaded);
      r  = $urandom_range(l, loaded);
      send(op, pick_value(3), l, r, $urandom_range(1, r - l + 1));
   endtask

   // one well-formed round: loads, a build, queries; a little noise mixed in
   task automatic run_round(int max_loads);
      repeat ($urandom_range(0, max_loads))
         if (loaded < MAX_ITEMS) send(OP_LOAD, pick_value(0), 0, 0, 0);
      if ($urandom_range(9) == 0) drain();
      send(OP_BUILD, 16'($urandom), $urandom, $urandom, $urandom);
      repeat ($urandom_range(6, 20)) begin
         if ($urandom_range(9) == 0)
            send(OP_W'($urandom_range(0, 7)), 16'($urandom), $urandom_range(0, 2047),
                 $urandom_range(0, 2047), $urandom_range(0, 2047));
         else if (loaded > 0)
            send_query();
      end
   endtask

   initial begin
      longint spans[5][2] = '{'{-32768, 32767}, '{-8, 7}, '{100, 100},
                              '{-300, -100}, '{0, 255}};
      req_bus.valid     <= 0;
      req_bus.opcode    <= OP_LOAD;
      req_bus.value     <= 0;
      req_bus.left_pos  <= 0;
      req_bus.right_pos <= 0;
      req_bus.k_rank    <= 0;
      csr_bus.valid     <= 0;
      csr_bus.index     <= CSR_VALUE_MIN;
      csr_bus.data      <= 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners on the reset interval [0, 255]
      send(OP_KTH, 0, 1, 1, 1);
      send(OP_BUILD, 0, 0, 0, 0);
      send(OP_CNT_EQ, 0, 1, 1, 0);
      send(OP_LOAD, 0, 0, 0, 0);
      send(OP_LOAD, 255, 0, 0, 0);
      send(OP_LOAD, 256, 0, 0, 0);
      send(OP_LOAD, 16'hffff, 0, 0, 0);
      send(OP_LOAD, 7, 0, 0, 0);
      send(OP_LOAD, 7, 0, 0, 0);
      send(OP_SPARE_A, 16'hffff, 2047, 2047, 2047);
      send(OP_SPARE_B, 16'h8000, 1024, 1024, 1024);
      send(OP_KTH, 0, 1, 4, 1);
      send(OP_BUILD, 0, 0, 0, 0);
      send(OP_KTH, 0, 1, 4, 1);
      send(OP_KTH, 0, 1, 4, 4);
      send(OP_KTH, 0, 1, 4, 0);
      send(OP_KTH, 0, 1, 4, 5);
      send(OP_CNT_GE, 0, 0, 4, 1);
      send(OP_CNT_GT, 0, 1, 5, 1);
      send(OP_CNT_EQ, 0, 3, 2, 1);
      send(OP_CNT_EQ, 7, 1, 4, 0);
      send(OP_CNT_GT, 7, 1, 4, 0);
      send(OP_CNT_GE, 7, 2, 4, 0);
      send(OP_CNT_GT, 16'h8000, 1, 4, 0);
      send(OP_CNT_GE, 16'h7fff, 1, 4, 0);

      // inverted interval: build refused, queries see no tree
      set_span(10, 5);
      send(OP_BUILD, 0, 0, 0, 0);
      send(OP_KTH, 0, 1, 1, 1);

      for (int p = 0; p < 5; p++) begin
         set_span(spans[p][0], spans[p][1]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         while (sent < 90 * (p + 1)) run_round(40);
      end

      // fill the store to the brim, then overflow it
      set_span(-32768, 32767);
      idle_pct  = 10;
      stall_pct = 10;
      while (loaded < MAX_ITEMS) send(OP_LOAD, pick_value(0), 0, 0, 0);
      send(OP_LOAD, 0, 0, 0, 0);
      send(OP_BUILD, 0, 0, 0, 0);
      send(OP_KTH, 0, 1, MAX_ITEMS, MAX_ITEMS);
      send(OP_CNT_GE, 16'h8000, 1, MAX_ITEMS, 0);
      repeat (20) send_query();

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
